[design/assertion_site_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Assertion site tracker assertion macros
// Concurrent check helpers that use the clk and rst of the including module.
// ----------------------------------------------------------------------------
`ifndef ASSERTION_SITE_TRACKER_MACROS_SVH
`define ASSERTION_SITE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define AST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion_site_tracker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion_site_tracker: next-cycle check failed");

`else

`define AST_ASSERT_SAME(label, ante, cons)
`define AST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[design/ast_pkg.sv]
// ----------------------------------------------------------------------------
// Assertion site tracker package
// Shared widths, defaults, payload layouts and the controller state type.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int HASH_W       = 32;
  localparam int COUNT_W      = 32;
  localparam int CNT_OUT_W    = 7;
  localparam int THRESH_W     = 16;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 88;

  localparam int DEF_SITE_SLOTS      = 64;
  localparam int DEF_FAILURE_RECORDS = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLED   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 8'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One slot of the open-addressing set.
  typedef struct packed {
    logic              used;
    logic [HASH_W-1:0] hash;
  } slot_entry_t;

  // Input tdata, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]        pad;
    logic              condition_held;
    logic [HASH_W-1:0] site_hash;
  } in_data_t;

  // Output tdata, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]           pad;
    logic                 fail_trip;
    logic                 set_full;
    logic                 newly_seen;
    logic [CNT_OUT_W-1:0] failures_stored;
    logic [CNT_OUT_W-1:0] distinct_sites;
    logic [COUNT_W-1:0]   failures_seen;
    logic [COUNT_W-1:0]   total_events;
  } out_data_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

[design/ast_start_idx.sv]
// ----------------------------------------------------------------------------
// Assertion site tracker start index unit
// Reduces a site hash modulo the slot count: a mask for a power of two,
// otherwise a reciprocal multiplication and one correcting subtraction,
// with quotient, product and remainder registered in turn.
// ----------------------------------------------------------------------------
module ast_start_idx #(
  parameter int SITE_SLOTS = ast_pkg::DEF_SITE_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ast_pkg::HASH_W-1:0]    hash,
  output logic                          done,
  output logic [$clog2(SITE_SLOTS)-1:0] idx
);

  localparam int IDX_W   = $clog2(SITE_SLOTS);
  localparam bit IS_POW2 = (SITE_SLOTS & (SITE_SLOTS - 1)) == 0;

  if (IS_POW2) begin : g_mask
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        idx <= hash[IDX_W-1:0];
      end
    end
  end else begin : g_recip
    // The slot count lies above 2^(IDX_W-1), so the reciprocal below fits in
    // 32 bits and the quotient estimate falls short by at most one. The first
    // remainder is then below twice the slot count.
    localparam int          SHIFT      = 31 + IDX_W;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(SITE_SLOTS);
    localparam logic [ast_pkg::HASH_W-1:0] RECIP = ast_pkg::HASH_W'(RECIP_WIDE);

    logic                           stage1;
    logic                           stage2;
    logic [2*ast_pkg::HASH_W-1:0]   product;
    logic [ast_pkg::HASH_W-1:0]     hash_q;
    logic [ast_pkg::HASH_W-1:0]     quot_q;
    logic [ast_pkg::HASH_W-1:0]     prod_q;
    logic [IDX_W:0]                 rem_q;

    assign product = (2*ast_pkg::HASH_W)'(hash) * (2*ast_pkg::HASH_W)'(RECIP);

    always_ff @(posedge clk) begin
      if (rst) begin
        stage1 <= 1'b0;
        stage2 <= 1'b0;
        done   <= 1'b0;
      end else begin
        stage1 <= start;
        stage2 <= stage1;
        done   <= stage2;
      end
      if (start) begin
        hash_q <= hash;
        quot_q <= ast_pkg::HASH_W'(product >> SHIFT);
      end
      if (stage1) begin
        prod_q <= quot_q * ast_pkg::HASH_W'(SITE_SLOTS);
      end
      if (stage2) begin
        rem_q <= (IDX_W + 1)'(hash_q - prod_q);
      end
    end

    assign idx = (rem_q >= (IDX_W + 1)'(SITE_SLOTS))
               ? IDX_W'(rem_q - (IDX_W + 1)'(SITE_SLOTS))
               : IDX_W'(rem_q);
  end

endmodule

[design/ast_slot_ram.sv]
// ----------------------------------------------------------------------------
// Assertion site tracker slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ast_slot_ram #(
  parameter int SITE_SLOTS = ast_pkg::DEF_SITE_SLOTS
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(SITE_SLOTS)-1:0] waddr,
  input  ast_pkg::slot_entry_t          wdata,
  input  logic [$clog2(SITE_SLOTS)-1:0] raddr,
  output ast_pkg::slot_entry_t          rdata
);

  ast_pkg::slot_entry_t mem [SITE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/assertion_site_tracker.sv]
// ----------------------------------------------------------------------------
// Assertion site tracker
// Counts assertion events and failures and keeps the distinct site hashes in
// a linear-probing set held in one synchronous slot memory.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                               content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser     event or clear
//  m_*       out        m_tvalid m_tready m_tdata             counts and flags
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data register write
//
// An event passes through the start index unit, then a memory read and a
// compare for each slot probed, and then its result is loaded for output;
// a slot count that is not a power of two takes the reciprocal path in the
// start index unit. A clear sweeps the memory; a disabled item goes straight
// to the result. After reset a sweep of all slots empties them first.
// A stalled output holds its result while the next item is taken and worked on.
module assertion_site_tracker #(
  parameter int SITE_SLOTS      = ast_pkg::DEF_SITE_SLOTS,
  parameter int FAILURE_RECORDS = ast_pkg::DEF_FAILURE_RECORDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] site_hash, [32] condition_held, [39:33] zero
  input  logic [ast_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] func
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] total_events, [63:32] failures_seen, [70:64] distinct_sites,
  // [77:71] failures_stored, [78] newly_seen, [79] set_full, [80] fail_trip,
  // [87:81] zero
  output logic [ast_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ast_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ast_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(SITE_SLOTS);
  localparam int SC_W  = $clog2(SITE_SLOTS + 1);
  localparam int FR_W  = $clog2(FAILURE_RECORDS + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SITE_SLOTS - 1);

  ast_pkg::state_t state, state_next;

  logic                           enabled;
  logic [ast_pkg::THRESH_W-1:0]   threshold;
  logic [ast_pkg::COUNT_W-1:0]    event_count;
  logic [ast_pkg::COUNT_W-1:0]    failure_count;
  logic [SC_W-1:0]                site_count;
  logic [FR_W-1:0]                stored_count;
  logic [ast_pkg::HASH_W-1:0]     hash_q;
  logic [IDX_W-1:0]               idx;
  logic [IDX_W-1:0]               probe_cnt;
  logic [IDX_W-1:0]               clr_addr;
  logic                           newly;
  logic                           full;
  logic                           trip;

  ast_pkg::in_data_t              in_data;
  ast_pkg::out_data_t             out_data;
  logic                           in_xfer;
  logic                           out_free;
  logic                           out_load;
  logic                           mod_start;
  logic                           mod_done;
  logic [IDX_W-1:0]               mod_idx;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  ast_pkg::slot_entry_t           mem_wdata;
  ast_pkg::slot_entry_t           mem_rdata;
  logic                           slot_free;
  logic                           slot_match;
  logic [ast_pkg::COUNT_W-1:0]    failure_inc;
  logic [ast_pkg::THRESH_W-1:0]   thr_eff;
  logic                           mem_wr_state;

  assign in_data    = ast_pkg::in_data_t'(s_tdata);
  assign in_xfer    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign cfg_ready  = 1'b1;
  assign slot_free  = !mem_rdata.used;
  assign slot_match = mem_rdata.hash == hash_q;
  assign failure_inc = ast_pkg::sat_inc(failure_count);
  assign thr_eff    = (threshold == '0) ? ast_pkg::THRESH_W'(1) : threshold;
  assign mem_wr_state = state == ast_pkg::ST_CHECK || state == ast_pkg::ST_CLEAR ||
                        state == ast_pkg::ST_INIT;

  ast_start_idx #(
    .SITE_SLOTS(SITE_SLOTS)
  ) u_start_idx (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .hash (in_data.site_hash),
    .done (mod_done),
    .idx  (mod_idx)
  );

  ast_slot_ram #(
    .SITE_SLOTS(SITE_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ast_pkg::ST_INIT: begin
        if (clr_addr == LAST_SLOT) state_next = ast_pkg::ST_IDLE;
      end
      ast_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (!enabled) state_next = ast_pkg::ST_DONE;
          else if (s_tuser) state_next = ast_pkg::ST_CLEAR;
          else state_next = ast_pkg::ST_HASH;
        end
      end
      ast_pkg::ST_HASH: begin
        if (mod_done) state_next = ast_pkg::ST_READ;
      end
      ast_pkg::ST_READ: state_next = ast_pkg::ST_CHECK;
      ast_pkg::ST_CHECK: begin
        if (slot_free || slot_match || probe_cnt == LAST_SLOT) begin
          state_next = ast_pkg::ST_DONE;
        end else begin
          state_next = ast_pkg::ST_READ;
        end
      end
      ast_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_SLOT) state_next = ast_pkg::ST_DONE;
      end
      ast_pkg::ST_DONE: begin
        if (out_free) state_next = ast_pkg::ST_IDLE;
      end
      default: state_next = ast_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mod_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '{used: 1'b1, hash: hash_q};
    out_load  = 1'b0;
    case (state)
      ast_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        mod_start = s_tvalid && enabled && !s_tuser;
      end
      ast_pkg::ST_CHECK: begin
        mem_we = slot_free;
      end
      ast_pkg::ST_INIT, ast_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ast_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data                 = '0;
    out_data.total_events    = event_count;
    out_data.failures_seen   = failure_count;
    out_data.distinct_sites  = ast_pkg::CNT_OUT_W'(site_count);
    out_data.failures_stored = ast_pkg::CNT_OUT_W'(stored_count);
    out_data.newly_seen      = newly;
    out_data.set_full        = full;
    out_data.fail_trip       = trip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ast_pkg::ST_INIT;
      enabled       <= 1'b1;
      threshold     <= ast_pkg::THRESH_W'(1);
      event_count   <= '0;
      failure_count <= '0;
      site_count    <= '0;
      stored_count  <= '0;
      clr_addr      <= '0;
      newly         <= 1'b0;
      full          <= 1'b0;
      trip          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ast_pkg::REG_ENABLED) begin
          enabled <= cfg_data[0];
        end else if (cfg_index == ast_pkg::REG_THRESHOLD) begin
          threshold <= cfg_data[ast_pkg::THRESH_W-1:0];
        end
      end

      if (state == ast_pkg::ST_IDLE && in_xfer) begin
        newly <= 1'b0;
        full  <= 1'b0;
        trip  <= 1'b0;
        if (enabled && s_tuser) begin
          event_count   <= '0;
          failure_count <= '0;
          site_count    <= '0;
          stored_count  <= '0;
        end else if (enabled) begin
          event_count <= ast_pkg::sat_inc(event_count);
          if (!in_data.condition_held) begin
            failure_count <= failure_inc;
            if (stored_count < FR_W'(FAILURE_RECORDS)) begin
              stored_count <= stored_count + FR_W'(1);
            end
            trip <= failure_inc >= ast_pkg::COUNT_W'(thr_eff);
          end
        end
      end

      // Outcome of one probe: a free slot takes the hash, a match ends the
      // walk, and a miss on the last untried slot means the set is full.
      if (state == ast_pkg::ST_CHECK) begin
        if (slot_free) begin
          newly      <= 1'b1;
          site_count <= site_count + SC_W'(1);
        end else if (!slot_match && probe_cnt == LAST_SLOT) begin
          full <= 1'b1;
        end
      end

      if (state == ast_pkg::ST_INIT || state == ast_pkg::ST_CLEAR) begin
        clr_addr <= (clr_addr == LAST_SLOT) ? '0 : clr_addr + IDX_W'(1);
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end

    if (state == ast_pkg::ST_IDLE && in_xfer) begin
      hash_q <= in_data.site_hash;
    end
    if (state == ast_pkg::ST_HASH && mod_done) begin
      idx       <= mod_idx;
      probe_cnt <= '0;
    end else if (state == ast_pkg::ST_CHECK) begin
      idx       <= (idx == LAST_SLOT) ? '0 : idx + IDX_W'(1);
      probe_cnt <= probe_cnt + IDX_W'(1);
    end
    if (out_load) begin
      m_tdata <= out_data;
    end
  end

`include "assertion_site_tracker_macros.svh"

  `AST_ASSERT_SAME(a_site_bound, 1'b1, site_count <= SC_W'(SITE_SLOTS))
  `AST_ASSERT_SAME(a_write_states, mem_we, mem_wr_state)
  `AST_ASSERT_SAME(a_flags_exclusive, m_tvalid, !(m_tdata[78] && m_tdata[79]))
  `AST_ASSERT_NEXT(a_leave_idle, s_tvalid && s_tready, state != ast_pkg::ST_IDLE)

endmodule

[tb/sv/tb_assertion_site_tracker.sv]
// ----------------------------------------------------------------------------
// Assertion site tracker testbench
// Streams assertion events and clear commands through the tracker. A scoreboard
// keeps its own copy of the site set and counters and checks every output
// transfer field by field. Several enable and threshold settings are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_assertion_site_tracker;

  localparam int SLOTS        = ast_pkg::DEF_SITE_SLOTS;
  localparam int RECORDS      = ast_pkg::DEF_FAILURE_RECORDS;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 40;
  localparam int MAX_PRINTS   = 40;
  localparam longint LIMIT_NS = 64'd24_000_000;

  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;
  localparam logic [ast_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 8'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] hash;
    logic        held;
  } site_item_t;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_style_t;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               s_tvalid  = 1'b0;
  logic                               s_tready;
  logic [ast_pkg::IN_DATA_W-1:0]      s_tdata   = '0;
  logic                               s_tuser   = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready  = 1'b0;
  logic [ast_pkg::OUT_DATA_W-1:0]     m_tdata;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [ast_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [ast_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

  // Scoreboard copy of the tracker state and its registers.
  logic        model_en = 1'b1;
  logic [15:0] model_thr = 16'd1;
  logic        slot_busy [SLOTS] = '{default: 1'b0};
  logic [31:0] slot_key [SLOTS] = '{default: 32'h0};
  logic [31:0] event_cnt = '0;
  logic [31:0] fail_cnt = '0;
  int          site_cnt = 0;
  int          stored_cnt = 0;

  site_item_t              event_queue [$];
  ast_pkg::out_data_t      predicted_counts [$];

  int err_cnt = 0;
  int n_results = 0, n_new = 0, n_full = 0, n_trip = 0, n_clear = 0, n_writes = 0;

  logic [15:0] round_thr [8] = '{16'd1, 16'd2, 16'd0, 16'd5, 16'hFFFF, 16'd17, 16'd3, 16'd40};

  assertion_site_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic ast_pkg::out_data_t apply_site_event(input site_item_t it);
    ast_pkg::out_data_t res;
    int                 start;
    int                 s;
    logic               done;
    logic [31:0]        limit;
    res = '0;
    if (model_en) begin
      if (it.func == FUNC_CLEAR) begin
        for (int k = 0; k < SLOTS; k++) slot_busy[k] = 1'b0;
        event_cnt  = '0;
        fail_cnt   = '0;
        site_cnt   = 0;
        stored_cnt = 0;
      end else begin
        if (event_cnt != '1) event_cnt = event_cnt + 1;
        start = int'(it.hash % SLOTS);
        done  = 1'b0;
        for (int k = 0; k < SLOTS && !done; k++) begin
          s = (start + k) % SLOTS;
          if (!slot_busy[s]) begin
            slot_busy[s] = 1'b1;
            slot_key[s]  = it.hash;
            site_cnt++;
            res.newly_seen = 1'b1;
            done = 1'b1;
          end else if (slot_key[s] == it.hash) begin
            done = 1'b1;
          end
        end
        // Every slot held some other site, so the hash is dropped.
        res.set_full = !done;
        if (!it.held) begin
          if (fail_cnt != '1) fail_cnt = fail_cnt + 1;
          if (stored_cnt < RECORDS) stored_cnt++;
          limit = (model_thr == 16'd0) ? 32'd1 : 32'(model_thr);
          res.fail_trip = (fail_cnt >= limit);
        end
      end
    end
    res.total_events    = event_cnt;
    res.failures_seen   = fail_cnt;
    res.distinct_sites  = 7'(site_cnt);
    res.failures_stored = 7'(stored_cnt);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  task automatic check_report(input ast_pkg::out_data_t got);
    ast_pkg::out_data_t want;
    if (predicted_counts.size() == 0) begin
      report_mismatch("result with none expected", got.total_events, '0);
    end else begin
      want = predicted_counts.pop_front();
      n_results++;
      if (want.newly_seen) n_new++;
      if (want.set_full) n_full++;
      if (want.fail_trip) n_trip++;
      if (got.total_events !== want.total_events)
        report_mismatch("total_events", got.total_events, want.total_events);
      if (got.failures_seen !== want.failures_seen)
        report_mismatch("failures_seen", got.failures_seen, want.failures_seen);
      if (got.distinct_sites !== want.distinct_sites)
        report_mismatch("distinct_sites", 32'(got.distinct_sites), 32'(want.distinct_sites));
      if (got.failures_stored !== want.failures_stored)
        report_mismatch("failures_stored", 32'(got.failures_stored),
                        32'(want.failures_stored));
      if (got.newly_seen !== want.newly_seen)
        report_mismatch("newly_seen", 32'(got.newly_seen), 32'(want.newly_seen));
      if (got.set_full !== want.set_full)
        report_mismatch("set_full", 32'(got.set_full), 32'(want.set_full));
      if (got.fail_trip !== want.fail_trip)
        report_mismatch("fail_trip", 32'(got.fail_trip), 32'(want.fail_trip));
      if (got.pad !== want.pad)
        report_mismatch("padding", 32'(got.pad), 32'(want.pad));
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  site_item_t drv_item = '0;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_tvalid && s_tready) predicted_counts.push_back(apply_site_event(drv_item));
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (event_queue.size() != 0) begin
          s_tvalid <= 1'b1;
          drv_item <= event_queue[0];
          s_tuser  <= event_queue[0].func;
          s_tdata  <= ast_pkg::in_data_t'{pad: '0, condition_held: event_queue[0].held,
                                          site_hash: event_queue[0].hash};
          void'(event_queue.pop_front());
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                       : $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by a toggle of hold_req.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold_ack <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_ack) begin
      hold_cnt <= LONG_HOLD;
      hold_ack <= hold_req;
    end
  end

  // Receiver: checks each output transfer and stalls on a changing pattern.
  rx_style_t rx_style = RX_OPEN;
  int        rx_left = 0;
  int        rx_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_report(m_tdata);
      if (rx_left == 0) begin
        rx_style <= rx_style_t'($urandom_range(0, 3));
        rx_left  <= $urandom_range(20, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_tick <= (rx_tick == 4) ? 0 : rx_tick + 1;
      case (rx_style)
        RX_OPEN:   m_tready <= (hold_cnt == 0);
        RX_MOSTLY: m_tready <= (hold_cnt == 0) && ($urandom_range(0, 3) != 0);
        RX_SPARSE: m_tready <= (hold_cnt == 0) && ($urandom_range(0, 3) == 0);
        default:   m_tready <= (hold_cnt == 0) && (rx_tick == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [ast_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ast_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ast_pkg::REG_ENABLED) model_en = val[0];
    else if (idx == ast_pkg::REG_THRESHOLD) model_thr = val[15:0];
    n_writes++;
    @(negedge clk);
  endtask

  task automatic queue_item(input logic func, input logic [31:0] hash, input logic held);
    event_queue.push_back('{func: func, hash: hash, held: held});
    if (func == FUNC_CLEAR) n_clear++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (event_queue.size() != 0 || s_tvalid || predicted_counts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_round(input int n_items);
    logic [31:0] pool [$];
    logic [31:0] h;
    int          pool_size;
    int          fail_pct;
    int          clear_pm;
    int          r;
    pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 90) : $urandom_range(3, 40);
    fail_pct  = $urandom_range(0, 100);
    clear_pm  = ($urandom_range(0, 2) == 0) ? 0 : 20;
    for (int k = 0; k < pool_size; k++) begin
      h = $urandom();
      // Many sites share a home slot so that probe chains grow long.
      if ($urandom_range(0, 1) == 1) h[5:0] = 6'($urandom_range(0, 7));
      pool.push_back(h);
    end
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 999);
      if (r < clear_pm)
        queue_item(FUNC_CLEAR, $urandom(), 1'($urandom_range(0, 1)));
      else if (r < clear_pm + 80)
        queue_item(FUNC_EVENT, $urandom(), 1'($urandom_range(0, 1)));
      else
        queue_item(FUNC_EVENT, pool[$urandom_range(0, pool_size - 1)],
                   $urandom_range(0, 99) >= fail_pct);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A threshold of zero must behave like one.
    write_reg(ast_pkg::REG_ENABLED, 32'h1);
    write_reg(ast_pkg::REG_THRESHOLD, 32'h0);
    queue_item(FUNC_EVENT, 32'h0000_0000, 1'b1);
    queue_item(FUNC_EVENT, 32'hFFFF_FFFF, 1'b0);
    queue_item(FUNC_EVENT, 32'h0000_0000, 1'b1);
    queue_item(FUNC_EVENT, 32'h0000_0040, 1'b1);
    // Home slot is the last one; the probe wraps around to the front.
    queue_item(FUNC_EVENT, 32'h0000_003F, 1'b0);
    queue_item(FUNC_EVENT, 32'h0000_0040, 1'b0);
    queue_item(FUNC_EVENT, 32'h8000_0000, 1'b1);
    queue_item(FUNC_EVENT, 32'h5555_5555, 1'b0);
    queue_item(FUNC_EVENT, 32'hAAAA_AAAA, 1'b0);
    queue_item(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b0);
    queue_item(FUNC_EVENT, 32'h0000_003F, 1'b1);
    queue_item(FUNC_CLEAR, 32'h0000_0000, 1'b1);
    queue_item(FUNC_CLEAR, 32'h1234_5678, 1'b0);
    queue_item(FUNC_EVENT, 32'h0000_0000, 1'b0);
    wait_drained();

    // Only the low 16 bits of the threshold count.
    write_reg(ast_pkg::REG_THRESHOLD, 32'hABCD_0002);
    queue_item(FUNC_EVENT, 32'h0000_0007, 1'b0);
    queue_item(FUNC_EVENT, 32'h0000_0007, 1'b0);
    queue_item(FUNC_EVENT, 32'h0000_0047, 1'b1);
    wait_drained();

    // Disabled: events and clears leave the counts alone.
    write_reg(ast_pkg::REG_ENABLED, 32'hFFFF_FFFE);
    queue_item(FUNC_EVENT, 32'hDEAD_BEEF, 1'b0);
    queue_item(FUNC_CLEAR, 32'h0000_0000, 1'b1);
    queue_item(FUNC_EVENT, 32'h0000_0007, 1'b1);
    wait_drained();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(ast_pkg::REG_ENABLED, 32'h1);
    write_reg(ast_pkg::REG_THRESHOLD, 32'd3);

    // Fill the set past capacity and push the stored failures to their bound.
    queue_item(FUNC_CLEAR, 32'h0, 1'b0);
    for (int k = 0; k < SLOTS + 8; k++)
      queue_item(FUNC_EVENT, (32'(k) << 6) | 32'(k % 5), (k % 8) == 0);
    for (int k = 0; k < 10; k++)
      queue_item(FUNC_EVENT, (32'(k) << 6) | 32'(k % 5), 1'b0);
    wait_drained();

    for (int r = 0; r < 8; r++) begin
      write_reg(ast_pkg::REG_THRESHOLD, {16'($urandom()), round_thr[r]});
      if (r == 5) begin
        write_reg(ast_pkg::REG_ENABLED, 32'h0);
        random_round(15);
        wait_drained();
        write_reg(ast_pkg::REG_ENABLED, 32'h1);
      end
      random_round(200);
      if (r == 2 || r == 6) hold_req = !hold_req;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d clears, %0d new sites, %0d full-set drops, %0d trips.",
             n_results, n_clear, n_new, n_full, n_trip);
    $display("Register writes: %0d, with thresholds from 0 to 65535 and tracking on and off.",
             n_writes);
    if (err_cnt == 0 && predicted_counts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_cnt, predicted_counts.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d results outstanding", predicted_counts.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/ast_pkg.sv
design/ast_start_idx.sv
design/ast_slot_ram.sv
design/assertion_site_tracker.sv
tb/sv/tb_assertion_site_tracker.sv
